// ----- hdl/bucket_lru_slot_manager_assert.svh -----
// assertion macros for the bucket slot manager checker
`ifndef BUCKET_LRU_SLOT_MANAGER_ASSERT_SVH
`define BUCKET_LRU_SLOT_MANAGER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BLSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define BLSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/blsm_pkg.sv -----
// ----------------------------------------------------------------------------
// blsm_pkg
// shared types and command codes of the bucket slot manager
// ----------------------------------------------------------------------------
`default_nettype none
package blsm_pkg;
  typedef enum logic [1:0] {
    CMD_PROMOTE  = 2'd0,
    CMD_ALLOCATE = 2'd1,
    CMD_WRITE    = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;
  localparam int unsigned IN_BITS  = 112;
  localparam int unsigned OUT_BITS = 168;
endpackage
`default_nettype wire

// ----- hdl/bucket_lru_slot_manager.sv -----
// ----------------------------------------------------------------------------
// bucket_lru_slot_manager
// recency-ordered bucket of slots with promote, allocate, write and read
// ----------------------------------------------------------------------------
// One transaction in, one result out, one at a time: a new transaction is
// taken only after the previous result has been accepted. Slot contents live
// in a synchronous memory (key+value per word) with a registered read port.
// Valid bits are flops cleared by reset; the memory is not. Read data is
// masked by the valid bit captured with it, so an invalid slot reads as key
// and value zero and no clearing pass is needed. Promote captures slot s,
// copies each slot from s+n upward down by n with a read and a write state
// per slot, then writes the captured word into each of the top n slots.
// Allocate scans the valid flops at one slot per cycle and, when no run is
// found, evicts from slot 0 upward, clearing each evicted slot and the
// slots after it that share its key.
`default_nettype none
module bucket_lru_slot_manager #(
  parameter int NUM_SLOTS = 32,
  parameter int KEY_BITS  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // command[1:0], slot_index[6:2], run_length[12:7], entry_key[44:13],
  // entry_value[108:45], zero fill
  input  wire logic [blsm_pkg::IN_BITS-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // start_slot[4:0], evicted_flag[5], evicted_value[69:6], read_key[101:70],
  // read_value[165:102], read_valid[166], status[167]
  output logic [blsm_pkg::OUT_BITS-1:0]        out_tdata
);
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1) + 1;
  localparam int WW = KEY_BITS + 64;

  typedef enum logic [3:0] {
    S_IDLE, S_RW, S_PR_CAP, S_PR_RD, S_PR_WR, S_PR_TOP,
    S_SC_RD, S_SC_CHK, S_EV_RD, S_EV_CHK, S_DONE
  } state_t;

  state_t state_r;
  // memory and valid flops
  logic [WW-1:0] mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic [WW-1:0] rdata_r;
  logic          rd_vld_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata;

  // captured request
  blsm_pkg::cmd_t cmd_r;
  logic [AW-1:0] s_r;
  logic [CW-1:0] n_r;
  logic [KEY_BITS-1:0] key_r;
  logic [63:0] val_r;
  // work registers
  logic [CW-1:0] pos_r, avail_r;
  logic [WW-1:0] cap_r;
  logic [KEY_BITS-1:0] evkey_r;
  logic clearing_r;
  logic [AW-1:0] start_r;
  logic evf_r;
  logic [63:0] evv_r;
  logic [KEY_BITS-1:0] rk_r;
  logic [63:0] rv_r;
  logic rvld_r, st_r;

  logic [1:0] in_cmd;
  logic [4:0] in_s;
  logic [5:0] in_n;
  assign in_cmd = in_tdata[1:0];
  assign in_s   = in_tdata[6:2];
  assign in_n   = in_tdata[12:7];

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata = {st_r, rvld_r, rv_r, 32'(rk_r), evv_r, evf_r, 5'(start_r)};

  // memory port, valid bit of the read slot captured with the data
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
    rd_vld_r <= valid_r[raddr];
  end

  // invalid slots read as zero
  logic [WW-1:0] rdata_m;
  assign rdata_m = rd_vld_r ? rdata_r : '0;

  logic [KEY_BITS-1:0] rkey;
  logic [63:0] rval;
  assign rkey = rdata_m[WW-1:64];
  assign rval = rdata_m[63:0];
  logic pos_vld;
  assign pos_vld = valid_r[pos_r[AW-1:0]];

  // address and write control
  always_comb begin
    raddr = pos_r[AW-1:0];
    we = 1'b0;
    waddr = pos_r[AW-1:0];
    wdata = cap_r;
    unique case (state_r)
      S_IDLE: raddr = AW'(in_s);
      S_RW: begin
        raddr = s_r;
        we = (cmd_r == blsm_pkg::CMD_WRITE) && !st_r;
        waddr = s_r;
        wdata = {key_r, val_r};
      end
      S_PR_RD: raddr = AW'(pos_r + n_r);
      S_PR_WR: begin
        we = 1'b1;
        wdata = rdata_m;
      end
      S_PR_TOP: we = 1'b1;
      S_EV_CHK: begin
        we = clearing_r ? (rkey == evkey_r) : pos_vld;
        wdata = '0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          cmd_r <= blsm_pkg::cmd_t'(in_cmd);
          s_r <= AW'(in_s);
          n_r <= CW'(in_n);
          key_r <= in_tdata[13 +: KEY_BITS];
          val_r <= in_tdata[108:45];
          pos_r <= (blsm_pkg::cmd_t'(in_cmd) == blsm_pkg::CMD_ALLOCATE) ? '0 : CW'(in_s);
          start_r <= '0; evf_r <= 1'b0; evv_r <= '0;
          rk_r <= '0; rv_r <= '0; rvld_r <= 1'b0;
          avail_r <= '0; clearing_r <= 1'b0;
          unique case (blsm_pkg::cmd_t'(in_cmd))
            blsm_pkg::CMD_PROMOTE: begin
              st_r <= (in_n == 0) || (32'(in_s) + 32'(in_n) > NUM_SLOTS);
              state_r <= ((in_n == 0) || (32'(in_s) + 32'(in_n) > NUM_SLOTS))
                         ? S_DONE : S_PR_CAP;
            end
            blsm_pkg::CMD_ALLOCATE: begin
              st_r <= (in_n == 0) || (32'(in_n) > NUM_SLOTS);
              state_r <= ((in_n == 0) || (32'(in_n) > NUM_SLOTS)) ? S_DONE : S_SC_CHK;
            end
            default: begin
              st_r <= (32'(in_s) >= NUM_SLOTS);
              state_r <= S_RW;
            end
          endcase
        end
        S_RW: begin
          if (cmd_r == blsm_pkg::CMD_WRITE && !st_r) valid_r[s_r] <= 1'b1;
          state_r <= (cmd_r == blsm_pkg::CMD_READ && !st_r) ? S_SC_RD : S_DONE;
        end
        S_SC_RD: begin
          // read data of slot s_r now in rdata_r (shared state for read cmd)
          if (cmd_r == blsm_pkg::CMD_READ) begin
            rk_r <= rkey; rv_r <= rval; rvld_r <= valid_r[s_r];
            state_r <= S_DONE;
          end else state_r <= S_SC_CHK;
        end
        // promote: capture slot s
        S_PR_CAP: begin
          cap_r <= rdata_m;
          state_r <= (32'(pos_r) < NUM_SLOTS - 32'(n_r)) ? S_PR_RD : S_PR_TOP;
        end
        S_PR_RD: state_r <= S_PR_WR;
        S_PR_WR: begin
          valid_r[pos_r[AW-1:0]] <= valid_r[AW'(pos_r + n_r)];
          pos_r <= pos_r + 1'b1;
          state_r <= (32'(pos_r) + 1 < NUM_SLOTS - 32'(n_r)) ? S_PR_RD : S_PR_TOP;
        end
        S_PR_TOP: begin
          valid_r[pos_r[AW-1:0]] <= 1'b1;
          pos_r <= pos_r + 1'b1;
          if (32'(pos_r) + 1 >= NUM_SLOTS) state_r <= S_DONE;
        end
        // allocate free-run scan over valid flops
        S_SC_CHK: begin
          if (avail_r == n_r) begin
            start_r <= AW'(pos_r - n_r);
            state_r <= S_DONE;
          end else if (32'(pos_r) >= NUM_SLOTS) begin
            pos_r <= '0;
            state_r <= S_EV_RD;
          end else begin
            avail_r <= pos_vld ? '0 : avail_r + 1'b1;
            pos_r <= pos_r + 1'b1;
          end
        end
        S_EV_RD: begin
          if (clearing_r && 32'(pos_r) < NUM_SLOTS) state_r <= S_EV_CHK;
          else if (32'(pos_r) >= NUM_SLOTS || pos_r >= n_r) begin
            start_r <= AW'(pos_r - n_r);
            state_r <= S_DONE;
          end else state_r <= S_EV_CHK;
        end
        S_EV_CHK: begin
          state_r <= S_EV_RD;
          if (clearing_r) begin
            if (rkey == evkey_r) begin
              valid_r[pos_r[AW-1:0]] <= 1'b0;
              pos_r <= pos_r + 1'b1;
            end else clearing_r <= 1'b0;
          end else if (!pos_vld) begin
            pos_r <= pos_r + 1'b1;
          end else begin
            evf_r <= 1'b1;
            evv_r <= rval;
            evkey_r <= rkey;
            clearing_r <= 1'b1;
            valid_r[pos_r[AW-1:0]] <= 1'b0;
            pos_r <= pos_r + 1'b1;
          end
        end
        S_DONE: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/blsm_checker.sv -----
// ----------------------------------------------------------------------------
// blsm_checker
// port-level checks of the bucket slot manager
// ----------------------------------------------------------------------------
`default_nettype none
`include "bucket_lru_slot_manager_assert.svh"
module blsm_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [167:0] out_tdata
);
  // one transaction at a time: no input taken while a result waits
  `BLSM_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  // stalled result holds
  `BLSM_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // accepted input is not ready next cycle
  `BLSM_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // out-of-range request carries no read valid mark
  `BLSM_ASSERT_IMP(a_status, clk, rst_n, out_tvalid && out_tdata[167], out_tdata[166] == 1'b0)
endmodule
bind bucket_lru_slot_manager blsm_checker u_blsm_checker (.*);
`default_nettype wire
